// ----- rtl/vst_pkg.sv -----
// Shared types and constants for the volume server table.
// Depends on nothing; the top level refers to it by scoped names.
package vst_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned SRV_W    = 64;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;

  // Request data: key in the low bits, then server.
  localparam int unsigned REQ_DATA_W = KEY_W + SRV_W;
  // Response data: status, server, slot, padded to whole bytes.
  localparam int unsigned RSP_BITS   = STATUS_W + SRV_W + SLOT_W;
  localparam int unsigned RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;
  localparam logic [SRV_W-1:0] NIL_SRV   = '0;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SPARE  = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_ABSENT   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_SCAN = 4'b0010,
    SQ_LAST = 4'b0100,
    SQ_DONE = 4'b1000
  } seq_state_e;

endpackage

// ----- rtl/volume_server_table_unit.sv -----
// Volume server table: key/server slot table searched linearly per request.
// Depends on vst_pkg (types, status and opcode codes).
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the opcode (lookup,
//   insert, remove), tdata the volume key and the server identifier. Each
//   request produces exactly one response on the m_axis channel carrying the
//   status, the server of the first matching slot and the slot number.
//   Every request walks all ENTRIES slots through one shared compare unit,
//   one slot read per cycle from the key and server memories. The block
//   takes no new request until the current one has been answered into the
//   output register. The output register holds a response while
//   m_axis_tready is low; a finished search waits for it to drain, and the
//   next request is accepted as soon as the result is parked there.
//   Reset (rst_ni low, asynchronous) clears the per-slot valid bits, so all
//   slots read as empty (all-ones key, nil server) at once; no clearing pass.
module volume_server_table_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] volume_key, [95:32] server_ident
  input  logic [vst_pkg::REQ_DATA_W-1:0]   s_axis_tdata,
  // [1:0] opcode
  input  logic [vst_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] status, [66:3] found_server, [70:67] slot_index, [71] zero
  output logic [vst_pkg::RSP_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Sequencer and captured request
  vst_pkg::seq_state_e             st_q, st_d;
  vst_pkg::opcode_e                op_q;
  logic [vst_pkg::KEY_W-1:0]       key_q;
  logic [vst_pkg::SRV_W-1:0]       srv_q;
  logic [IDX_W-1:0]                idx_q;

  // Slot storage: memories plus reset-cleared valid bits
  logic [vst_pkg::KEY_W-1:0]       key_mem [ENTRIES];
  logic [vst_pkg::SRV_W-1:0]       srv_mem [ENTRIES];
  logic [ENTRIES-1:0]              valid_q;

  // Registered read port
  logic [vst_pkg::KEY_W-1:0]       rd_key_q;
  logic [vst_pkg::SRV_W-1:0]       rd_srv_q;
  logic [IDX_W-1:0]                rd_idx_q;
  logic                            rd_ent_vld_q;
  logic                            rd_vld_q;

  // Search results
  logic                            hit_q;
  logic [IDX_W-1:0]                hit_idx_q;
  logic [vst_pkg::SRV_W-1:0]       found_q;
  logic                            emp_q;
  logic [IDX_W-1:0]                emp_idx_q;

  // Output register
  logic                            out_vld_q;
  vst_pkg::status_e                out_status_q;
  logic [vst_pkg::SRV_W-1:0]       out_found_q;
  logic [vst_pkg::SLOT_W-1:0]      out_slot_q;

  logic                            req_acc;
  logic                            out_free;
  logic                            finish;
  logic [vst_pkg::KEY_W-1:0]       eff_key;
  logic [vst_pkg::SRV_W-1:0]       eff_srv;
  vst_pkg::status_e                status_d;
  logic [IDX_W-1:0]                slot_d;
  logic [IDX_W+vst_pkg::SLOT_W-1:0] slot_ext;
  logic                            ins_we;
  logic                            rem_clr;

  assign s_axis_tready = (st_q == vst_pkg::SQ_IDLE);
  assign req_acc       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign finish        = (st_q == vst_pkg::SQ_DONE) && out_free;

  // Sequencer: walk the slots, drain the last compare, then answer.
  always_comb begin
    st_d = st_q;
    case (st_q)
      vst_pkg::SQ_IDLE: if (req_acc) st_d = vst_pkg::SQ_SCAN;
      vst_pkg::SQ_SCAN: if (idx_q == LAST_IDX) st_d = vst_pkg::SQ_LAST;
      vst_pkg::SQ_LAST: st_d = vst_pkg::SQ_DONE;
      vst_pkg::SQ_DONE: if (out_free) st_d = vst_pkg::SQ_IDLE;
      default:          st_d = vst_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= vst_pkg::SQ_IDLE;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      rd_vld_q <= (st_q == vst_pkg::SQ_SCAN);
      if (req_acc) begin
        idx_q <= '0;
      end else if (st_q == vst_pkg::SQ_SCAN && idx_q != LAST_IDX) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q  <= vst_pkg::opcode_e'(s_axis_tuser);
      key_q <= s_axis_tdata[vst_pkg::KEY_W-1:0];
      srv_q <= s_axis_tdata[vst_pkg::REQ_DATA_W-1:vst_pkg::KEY_W];
    end
  end

  // Memories: one write port (insert), one registered read port (scan)
  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      key_mem[emp_idx_q] <= key_q;
    end
    rd_key_q <= key_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      srv_mem[emp_idx_q] <= srv_q;
    end
    rd_srv_q <= srv_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= idx_q;
    rd_ent_vld_q <= valid_q[idx_q];
  end

  // Valid bits: set on insert, drop on remove; a clear slot reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ins_we)  valid_q[emp_idx_q] <= 1'b1;
      if (rem_clr) valid_q[hit_idx_q] <= 1'b0;
    end
  end

  // Shared compare unit: one slot per cycle, keep the first hit and first empty.
  assign eff_key = rd_ent_vld_q ? rd_key_q : vst_pkg::EMPTY_KEY;
  assign eff_srv = rd_ent_vld_q ? rd_srv_q : vst_pkg::NIL_SRV;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      emp_q <= 1'b0;
    end else if (req_acc) begin
      hit_q <= 1'b0;
      emp_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (!hit_q && eff_key == key_q)              hit_q <= 1'b1;
      if (!emp_q && eff_key == vst_pkg::EMPTY_KEY) emp_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      found_q   <= vst_pkg::NIL_SRV;
      hit_idx_q <= '0;
      emp_idx_q <= '0;
    end else if (rd_vld_q) begin
      if (!hit_q && eff_key == key_q) begin
        found_q   <= eff_srv;
        hit_idx_q <= rd_idx_q;
      end
      if (!emp_q && eff_key == vst_pkg::EMPTY_KEY) begin
        emp_idx_q <= rd_idx_q;
      end
    end
  end

  // Decide the outcome and the table update
  always_comb begin
    status_d = hit_q ? vst_pkg::ST_OK : vst_pkg::ST_ABSENT;
    slot_d   = hit_idx_q;
    ins_we   = 1'b0;
    rem_clr  = 1'b0;
    case (op_q)
      vst_pkg::OP_INSERT: begin
        if (found_q != vst_pkg::NIL_SRV) begin
          status_d = vst_pkg::ST_PRESENT;
        end else if (!emp_q) begin
          status_d = vst_pkg::ST_FULL;
          slot_d   = '0;
        end else begin
          status_d = vst_pkg::ST_OK;
          slot_d   = emp_idx_q;
          ins_we   = finish;
        end
      end
      vst_pkg::OP_REMOVE: begin
        if (found_q != srv_q) begin
          status_d = vst_pkg::ST_MISMATCH;
        end else if (!hit_q) begin
          status_d = vst_pkg::ST_ABSENT;
        end else begin
          status_d = vst_pkg::ST_OK;
          rem_clr  = finish;
        end
      end
      default: ;
    endcase
  end

  // Report only the low bits of the slot number
  assign slot_ext = {{vst_pkg::SLOT_W{1'b0}}, slot_d};

  // Output register: hold the response until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (finish) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_status_q <= status_d;
      out_found_q  <= found_q;
      out_slot_q   <= slot_ext[vst_pkg::SLOT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = vst_pkg::RSP_DATA_W'({out_slot_q, out_found_q, out_status_q});

  // Checks

  // The answer step is reached only after the last slot has been compared.
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == vst_pkg::SQ_DONE && $past(st_q) != vst_pkg::SQ_DONE)
      |-> $past(st_q) == vst_pkg::SQ_LAST)
    else $error("answer step entered without draining the last compare");

  // No compare is in flight when a new request is taken.
  a_idle_no_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> !rd_vld_q)
    else $error("request taken while a compare is still pending");

  // Searching for the empty key: the first empty slot is also a hit.
  a_empty_key_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == vst_pkg::SQ_DONE && key_q == vst_pkg::EMPTY_KEY && emp_q)
      |-> (hit_q && hit_idx_q == emp_idx_q))
    else $error("empty key search disagrees with first empty slot");

  // A full table never reports a slot.
  a_full_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q == vst_pkg::ST_FULL) |-> out_slot_q == '0)
    else $error("table full response carries a slot number");

endmodule
